### rtl/wstd_pkg.sv
package wstd_pkg;

  // field widths fixed by the interface
  localparam int HANDLE_W = 16;
  localparam int ENTRY_W  = 17;
  localparam int STOP_BIT = 16;
  localparam int QID_W    = 4;
  localparam int AW_W     = 5;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 3;

  // defaults for the top level parameters
  localparam int WORKERS_DEF = 4;
  localparam int DEPTH_DEF   = 64;

  localparam logic [AW_W-1:0] AW_RESET = 5'd4;

  // request kinds
  localparam logic [REQ_W-1:0] REQ_PUSH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP  = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_PUSHED = 3'd0;
  localparam logic [STAT_W-1:0] ST_GRANT  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_STOP   = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic             found;
    logic [QID_W-1:0] q;
  } scan_res_t;

  // a mod n for a below 16 and n in 1..16, restoring remainder in four steps
  function automatic logic [QID_W-1:0] mod_small(input logic [QID_W-1:0] a,
                                                 input logic [AW_W-1:0] n);
    logic [8:0] r;
    logic [8:0] d;
    int         i;
    r = {5'd0, a};
    for (i = 3; i >= 0; i--) begin
      d = {4'd0, n} << i;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[QID_W-1:0];
  endfunction

endpackage

### rtl/wstd_scan.sv
module wstd_scan #(
  parameter int WORKERS = wstd_pkg::WORKERS_DEF
) (
  input  logic [WORKERS-1:0]         nonempty,
  input  logic [wstd_pkg::QID_W-1:0] start,
  output wstd_pkg::scan_res_t        res
);

  // first nonempty queue at or after start, else first from queue zero
  always_comb begin
    logic                       hi_f;
    logic                       lo_f;
    logic [wstd_pkg::QID_W-1:0] hi_q;
    logic [wstd_pkg::QID_W-1:0] lo_q;
    hi_f = 1'b0;
    lo_f = 1'b0;
    hi_q = '0;
    lo_q = '0;
    for (int j = WORKERS - 1; j >= 0; j--) begin
      if (nonempty[j]) begin
        lo_f = 1'b1;
        lo_q = wstd_pkg::QID_W'(j);
        if (wstd_pkg::QID_W'(j) >= start) begin
          hi_f = 1'b1;
          hi_q = wstd_pkg::QID_W'(j);
        end
      end
    end
    res.found = lo_f;
    res.q     = hi_f ? hi_q : lo_q;
  end

endmodule

### rtl/work_stealing_task_dispatcher.sv
// work-stealing task dispatcher: one fifo of task handles per worker
//
// in channel (in_tvalid/in_tready): in_tuser = request kind (push, fetch, stop),
// in_tdata = task handle and worker index. out channel (out_tvalid/out_tready):
// out_tuser = status, out_tdata = granted task and source queue. exactly one
// result transaction per request transaction. cfg_wr_en/cfg_wr_data set the
// number of active queues; write it only while the block is idle.
//
// one request is worked at a time. steps from accept to result valid:
//   push or unknown kind: EXEC state, then the output register
//   fetch: as push when all queues are empty, else EXEC, READ, output register;
//     READ takes the registered memory read and writes a popped stop token back
//   stop: STOP steps through the active queues, one entry memory write per queue with room
// a new request is accepted only in the idle state
//
// reset empties every queue, clears the round-robin index and sets the
// active queue count to 4. the entry memory itself is not cleared.
// when the receiver stalls, the result waits in the output register and one
// further request is still accepted; its result parks in a holding register
// and no more requests are taken until the output drains.
module work_stealing_task_dispatcher #(
  parameter int WORKERS     = wstd_pkg::WORKERS_DEF,
  parameter int QUEUE_DEPTH = wstd_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // request stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [15:0] task_handle, [19:16] worker_index, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] granted_task, [19:16] source_queue, rest zero
  output logic [2:0]  out_tuser,  // [2:0] status
  // active worker count
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = (WORKERS * QUEUE_DEPTH > 1) ? $clog2(WORKERS * QUEUE_DEPTH) : 1;
  localparam int QI_W   = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int MEM_N  = WORKERS * QUEUE_DEPTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_STOP = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  function automatic logic [ADDR_W-1:0] ent_addr(input logic [wstd_pkg::QID_W-1:0] q,
                                                 input logic [PTR_W-1:0] p);
    return ADDR_W'(32'(q) * QUEUE_DEPTH + 32'(p));
  endfunction

  function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // control state
  logic [2:0]                  state_r, state_nxt;
  logic [wstd_pkg::AW_W-1:0]   aw_r;
  logic [PTR_W-1:0]            heads_r [WORKERS];
  logic [PTR_W-1:0]            heads_nxt [WORKERS];
  logic [PTR_W-1:0]            tails_r [WORKERS];
  logic [PTR_W-1:0]            tails_nxt [WORKERS];
  logic [CNT_W-1:0]            counts_r [WORKERS];
  logic [CNT_W-1:0]            counts_nxt [WORKERS];
  logic [wstd_pkg::QID_W-1:0]  npq_r, npq_nxt;
  logic                        out_valid_r;

  // request being worked
  logic [wstd_pkg::REQ_W-1:0]    req_r;
  logic [wstd_pkg::HANDLE_W-1:0] handle_r;
  logic [wstd_pkg::QID_W-1:0]    widx_r;
  logic [wstd_pkg::QID_W-1:0]    fq_r, fq_nxt;
  logic [wstd_pkg::QID_W-1:0]    stop_i_r, stop_i_nxt;
  logic [wstd_pkg::STAT_W-1:0]   stop_st_r, stop_st_nxt;
  logic [wstd_pkg::QID_W-1:0]    stop_src_r, stop_src_nxt;

  // held and delivered results
  logic [wstd_pkg::STAT_W-1:0]   res_st_r;
  logic [wstd_pkg::HANDLE_W-1:0] res_task_r;
  logic [wstd_pkg::QID_W-1:0]    res_src_r;
  logic [wstd_pkg::STAT_W-1:0]   out_st_r;
  logic [wstd_pkg::HANDLE_W-1:0] out_task_r;
  logic [wstd_pkg::QID_W-1:0]    out_src_r;

  // entry memory: bit 16 marks a stop token, bits 15..0 the handle
  logic [wstd_pkg::ENTRY_W-1:0] mem [MEM_N];
  logic [wstd_pkg::ENTRY_W-1:0] rd_data_r;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_waddr;
  logic [wstd_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [ADDR_W-1:0]            mem_raddr;

  logic [wstd_pkg::AW_W-1:0]   n_eff;
  logic [wstd_pkg::QID_W-1:0]  q_push;
  logic [wstd_pkg::QID_W-1:0]  q_start;
  logic [WORKERS-1:0]          nonempty;
  wstd_pkg::scan_res_t         scan;
  logic                        slot_free;
  logic                        in_acc;

  logic                          fin;
  logic [wstd_pkg::STAT_W-1:0]   fin_st;
  logic [wstd_pkg::HANDLE_W-1:0] fin_task;
  logic [wstd_pkg::QID_W-1:0]    fin_src;
  logic                          out_load;
  logic                          res_load;
  logic [wstd_pkg::STAT_W-1:0]   out_st_nxt;
  logic [wstd_pkg::HANDLE_W-1:0] out_task_nxt;
  logic [wstd_pkg::QID_W-1:0]    out_src_nxt;

  // a count of zero acts as one, above WORKERS acts as WORKERS
  always_comb begin
    if (aw_r == '0) begin
      n_eff = wstd_pkg::AW_W'(1);
    end else if (aw_r > wstd_pkg::AW_W'(WORKERS)) begin
      n_eff = wstd_pkg::AW_W'(WORKERS);
    end else begin
      n_eff = aw_r;
    end
  end

  assign q_push  = wstd_pkg::mod_small(npq_r, n_eff);
  assign q_start = wstd_pkg::mod_small(widx_r, n_eff);

  // empty flags of the queues in use feed the scan
  always_comb begin
    for (int j = 0; j < WORKERS; j++) begin
      nonempty[j] = (counts_r[j] != '0) && (wstd_pkg::AW_W'(j) < n_eff);
    end
  end

  wstd_scan #(
    .WORKERS (WORKERS)
  ) u_scan (
    .nonempty (nonempty),
    .start    (q_start),
    .res      (scan)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // request sequencer
  always_comb begin
    logic [QI_W-1:0]            qi;
    logic [wstd_pkg::AW_W-1:0]  q_inc;
    state_nxt    = state_r;
    heads_nxt    = heads_r;
    tails_nxt    = tails_r;
    counts_nxt   = counts_r;
    npq_nxt      = npq_r;
    fq_nxt       = fq_r;
    stop_i_nxt   = stop_i_r;
    stop_st_nxt  = stop_st_r;
    stop_src_nxt = stop_src_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    fin          = 1'b0;
    fin_st       = wstd_pkg::ST_NONE;
    fin_task     = '0;
    fin_src      = '0;
    out_load     = 1'b0;
    res_load     = 1'b0;
    out_st_nxt   = res_st_r;
    out_task_nxt = res_task_r;
    out_src_nxt  = res_src_r;
    qi           = '0;
    q_inc        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (req_r)
          wstd_pkg::REQ_PUSH: begin
            qi    = q_push[QI_W-1:0];
            q_inc = {1'b0, q_push} + wstd_pkg::AW_W'(1);
            // round-robin index moves on even when the push is dropped
            npq_nxt = (q_inc == n_eff) ? '0 : q_inc[wstd_pkg::QID_W-1:0];
            fin     = 1'b1;
            fin_src = q_push;
            if (counts_r[qi] == FULL_CNT) begin
              fin_st = wstd_pkg::ST_FULL;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = ent_addr(q_push, tails_r[qi]);
              mem_wdata      = {1'b0, handle_r};
              tails_nxt[qi]  = ptr_adv(tails_r[qi]);
              counts_nxt[qi] = counts_r[qi] + CNT_W'(1);
              fin_st         = wstd_pkg::ST_PUSHED;
            end
          end
          wstd_pkg::REQ_FETCH: begin
            if (scan.found) begin
              qi        = scan.q[QI_W-1:0];
              mem_re    = 1'b1;
              mem_raddr = ent_addr(scan.q, heads_r[qi]);
              fq_nxt    = scan.q;
              state_nxt = S_READ;
            end else begin
              fin     = 1'b1;
              fin_st  = wstd_pkg::ST_NONE;
              fin_src = q_start;
            end
          end
          wstd_pkg::REQ_STOP: begin
            stop_i_nxt   = '0;
            stop_st_nxt  = wstd_pkg::ST_PUSHED;
            stop_src_nxt = '0;
            state_nxt    = S_STOP;
          end
          default: begin
            fin     = 1'b1;
            fin_st  = wstd_pkg::ST_NONE;
            fin_src = '0;
          end
        endcase
      end
      S_READ: begin
        qi            = fq_r[QI_W-1:0];
        heads_nxt[qi] = ptr_adv(heads_r[qi]);
        fin           = 1'b1;
        fin_src       = fq_r;
        if (rd_data_r[wstd_pkg::STOP_BIT]) begin
          // stop token goes back to the tail, count is unchanged
          mem_we        = 1'b1;
          mem_waddr     = ent_addr(fq_r, tails_r[qi]);
          mem_wdata     = {1'b1, {wstd_pkg::HANDLE_W{1'b0}}};
          tails_nxt[qi] = ptr_adv(tails_r[qi]);
          fin_st        = wstd_pkg::ST_STOP;
        end else begin
          counts_nxt[qi] = counts_r[qi] - CNT_W'(1);
          fin_st         = wstd_pkg::ST_GRANT;
          fin_task       = rd_data_r[wstd_pkg::HANDLE_W-1:0];
        end
      end
      S_STOP: begin
        qi = stop_i_r[QI_W-1:0];
        if (counts_r[qi] == FULL_CNT) begin
          // report the first full queue only
          if (stop_st_r == wstd_pkg::ST_PUSHED) begin
            stop_st_nxt  = wstd_pkg::ST_FULL;
            stop_src_nxt = stop_i_r;
          end
        end else begin
          mem_we         = 1'b1;
          mem_waddr      = ent_addr(stop_i_r, tails_r[qi]);
          mem_wdata      = {1'b1, {wstd_pkg::HANDLE_W{1'b0}}};
          tails_nxt[qi]  = ptr_adv(tails_r[qi]);
          counts_nxt[qi] = counts_r[qi] + CNT_W'(1);
        end
        q_inc = {1'b0, stop_i_r} + wstd_pkg::AW_W'(1);
        if (q_inc == n_eff) begin
          fin     = 1'b1;
          fin_st  = stop_st_nxt;
          fin_src = stop_src_nxt;
        end else begin
          stop_i_nxt = q_inc[wstd_pkg::QID_W-1:0];
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a finished result goes straight out, or parks while the output is busy
    if (fin) begin
      out_st_nxt   = fin_st;
      out_task_nxt = fin_task;
      out_src_nxt  = fin_src;
      if (slot_free) begin
        out_load  = 1'b1;
        state_nxt = S_IDLE;
      end else begin
        res_load  = 1'b1;
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      aw_r        <= wstd_pkg::AW_RESET;
      npq_r       <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < WORKERS; j++) begin
        heads_r[j]  <= '0;
        tails_r[j]  <= '0;
        counts_r[j] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      npq_r    <= npq_nxt;
      heads_r  <= heads_nxt;
      tails_r  <= tails_nxt;
      counts_r <= counts_nxt;
      if (cfg_wr_en) begin
        aw_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r    <= in_tuser;
      handle_r <= in_tdata[15:0];
      widx_r   <= in_tdata[19:16];
    end
    fq_r       <= fq_nxt;
    stop_i_r   <= stop_i_nxt;
    stop_st_r  <= stop_st_nxt;
    stop_src_r <= stop_src_nxt;
    if (res_load) begin
      res_st_r   <= out_st_nxt;
      res_task_r <= out_task_nxt;
      res_src_r  <= out_src_nxt;
    end
    if (out_load) begin
      out_st_r   <= out_st_nxt;
      out_task_r <= out_task_nxt;
      out_src_r  <= out_src_nxt;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {4'd0, out_src_r, out_task_r};

endmodule

### rtl/wstd_checker.sv
module wstd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        cfg_wr_en
);

  // one request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request accepted while the previous one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= wstd_pkg::ST_FULL))
    else $error("status code out of range");

  // a handle only travels with a grant
  a_task_only_on_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser != wstd_pkg::ST_GRANT)) |-> (out_tdata[15:0] == 16'd0))
    else $error("task handle shown without a grant");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result dropped or changed");

  // worker count written only with nothing in work and no result waiting
  a_cfg_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> (in_tready && !out_tvalid))
    else $error("worker count written while a request is in flight");

endmodule

bind work_stealing_task_dispatcher wstd_checker u_wstd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_tvalid   (in_tvalid),
  .in_tready   (in_tready),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tuser   (out_tuser),
  .cfg_wr_en   (cfg_wr_en)
);

### bench/tb_work_stealing_task_dispatcher.sv
`timescale 1ns / 1ps

module tb_work_stealing_task_dispatcher;
  import wstd_pkg::*;

  // the block is built with its default queue count and depth
  localparam int NQ    = WORKERS_DEF;
  localparam int DEPTH = DEPTH_DEF;

  // request kind the block does not decode, answered as "no task"
  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // queue entry that marks a stop token, handle bits zero
  localparam logic [ENTRY_W-1:0] STOP_TOKEN = {1'b1, {HANDLE_W{1'b0}}};

  // one result transaction, split into its fields
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [HANDLE_W-1:0] handle;
    logic [QID_W-1:0]    queue;
  } dispatch_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;     // [15:0] task_handle, [19:16] worker_index, rest zero
  logic [1:0]  in_tuser;     // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;    // [15:0] granted_task, [19:16] source_queue, rest zero
  logic [2:0]  out_tuser;    // [2:0] status
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;

  // shadow copy of the dispatcher: per-queue fifos, round-robin pointer, worker count
  logic [ENTRY_W-1:0] q_entry [NQ][DEPTH];
  int                 q_head  [NQ] = '{default: 0};
  int                 q_tail  [NQ] = '{default: 0};
  int                 q_count [NQ] = '{default: 0};
  int                 rr_next = 0;
  logic [AW_W-1:0]    workers_cfg = AW_RESET;

  // results predicted at request accept, oldest first
  dispatch_result_t   pending_results [$];

  int err_count   = 0;
  bit in_gaps     = 1'b1;   // sender idles for a random gap before each request
  bit out_gaps    = 1'b1;   // receiver stalls for a random gap before each result
  int hold_cycles = 0;      // long receiver hold-off, counted down by the result sink

  work_stealing_task_dispatcher #(
    .WORKERS    (NQ),
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // dispatcher prediction
  // ---------------------------------------------------------------------------

  // queues in use: zero acts as one, anything above the build size is clipped
  function automatic int live_queues();
    if (workers_cfg == 0) return 1;
    if (workers_cfg > NQ) return NQ;
    return int'(workers_cfg);
  endfunction

  // append to a queue, refused when the queue is full
  function automatic bit queue_put(int q, logic [ENTRY_W-1:0] entry);
    if (q_count[q] >= DEPTH) return 1'b0;
    q_entry[q][q_tail[q]] = entry;
    q_tail[q] = (q_tail[q] + 1) % DEPTH;
    q_count[q]++;
    return 1'b1;
  endfunction

  // pop the head of a queue that is known to be non-empty
  function automatic logic [ENTRY_W-1:0] queue_take(int q);
    logic [ENTRY_W-1:0] entry;
    entry = q_entry[q][q_head[q]];
    q_head[q] = (q_head[q] + 1) % DEPTH;
    q_count[q]--;
    return entry;
  endfunction

  // update the shadow queues for one request and return the result it yields
  function automatic dispatch_result_t predict_dispatch(logic [REQ_W-1:0]    kind,
                                                        logic [HANDLE_W-1:0] handle,
                                                        logic [QID_W-1:0]    widx);
    dispatch_result_t   r;
    logic [ENTRY_W-1:0] entry;
    int                 n;
    int                 q;
    int                 start;
    bit                 found;
    n        = live_queues();
    r        = '0;
    r.status = ST_NONE;
    found    = 1'b0;
    case (kind)
      REQ_PUSH: begin
        // round-robin target, pointer moves on even when the push is dropped
        q        = rr_next % n;
        rr_next  = (q + 1) % n;
        r.status = queue_put(q, {1'b0, handle}) ? ST_PUSHED : ST_FULL;
        r.queue  = q[QID_W-1:0];
      end
      REQ_FETCH: begin
        // scan from the worker's own queue, wrapping, first non-empty wins
        start   = int'(widx) % n;
        r.queue = start[QID_W-1:0];
        for (int i = 0; i < n; i++) begin
          q = (start + i) % n;
          if (!found && q_count[q] != 0) begin
            found   = 1'b1;
            entry   = queue_take(q);
            r.queue = q[QID_W-1:0];
            if (entry[STOP_BIT]) begin
              // stop token goes back to the tail so every worker sees it
              void'(queue_put(q, STOP_TOKEN));
              r.status = ST_STOP;
            end else begin
              r.status = ST_GRANT;
              r.handle = entry[HANDLE_W-1:0];
            end
          end
        end
      end
      REQ_STOP: begin
        // token into every active queue with room, first full queue reported
        r.status = ST_PUSHED;
        for (int i = 0; i < n; i++) begin
          if (!queue_put(i, STOP_TOKEN) && r.status == ST_PUSHED) begin
            r.status = ST_FULL;
            r.queue  = i[QID_W-1:0];
          end
        end
      end
      default: begin
        // unknown kind: state untouched, answered as no task
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // drive one request transaction and record its predicted result on accept
  task automatic send_request(logic [REQ_W-1:0]    kind,
                              logic [HANDLE_W-1:0] handle,
                              logic [QID_W-1:0]    widx);
    int gap;
    gap = in_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  <= kind;
    in_tdata  <= {4'd0, widx, handle};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_dispatch(kind, handle, widx));
  endtask

  // random request; push share given per thousand, the rest mostly fetches
  task automatic send_random(int push_pml);
    int               pick;
    logic [REQ_W-1:0] kind;
    pick = $urandom_range(0, 999);
    if (pick < push_pml) begin
      kind = REQ_PUSH;
    end else if (pick < 950) begin
      kind = REQ_FETCH;
    end else if (pick < 985) begin
      kind = REQ_UNKNOWN;
    end else begin
      kind = REQ_STOP;
    end
    send_request(kind, HANDLE_W'($urandom), QID_W'($urandom_range(0, 15)));
  endtask

  // drop valid and hold the sender until every predicted result is back
  task automatic wait_for_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // worker count write, only ever with the block idle
  task automatic set_workers(logic [AW_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    workers_cfg = value;
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // result sink: random stall per result, plus the long hold-off when requested
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = out_gaps ? $urandom_range(0, 9) : 0;
      while (stall > 0 || hold_cycles > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        if (hold_cycles > 0) begin
          hold_cycles--;
        end else begin
          stall--;
        end
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // compare every accepted result transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    dispatch_result_t got;
    dispatch_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.handle = out_tdata[HANDLE_W-1:0];
      got.queue  = out_tdata[HANDLE_W +: QID_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d task %h queue %0d",
                 $time, got.status, got.handle, got.queue);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          err_count++;
        end
        if (got.handle !== want.handle) begin
          $display("%0t: granted_task expected %h actual %h", $time, want.handle, got.handle);
          err_count++;
        end
        if (got.queue !== want.queue) begin
          $display("%0t: source_queue expected %0d actual %0d", $time, want.queue, got.queue);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // hand-picked sequence at the reset worker count of four
  task automatic test_directed();
    send_request(REQ_FETCH,   16'h0000, 4'd0);   // all queues empty
    send_request(REQ_FETCH,   16'hffff, 4'd15);  // worker out of range, scan starts at 15 mod 4
    send_request(REQ_UNKNOWN, 16'hffff, 4'd15);  // undecoded kind changes nothing
    send_request(REQ_PUSH,    16'h0000, 4'd0);   // round robin fills queues 0..3
    send_request(REQ_PUSH,    16'hffff, 4'd15);
    send_request(REQ_PUSH,    16'ha5a5, 4'd3);
    send_request(REQ_PUSH,    16'h5a5a, 4'd12);
    send_request(REQ_FETCH,   16'h0000, 4'd2);   // own queue
    send_request(REQ_FETCH,   16'h0000, 4'd2);   // steals from the next queue
    send_request(REQ_FETCH,   16'h0000, 4'd6);   // scan wraps back to queue 0
    send_request(REQ_STOP,    16'h0000, 4'd0);   // token into every queue
    send_request(REQ_FETCH,   16'h0000, 4'd1);   // task still ahead of the token
    send_request(REQ_FETCH,   16'h0000, 4'd1);   // token seen and put back
    send_request(REQ_FETCH,   16'h0000, 4'd0);
    send_request(REQ_PUSH,    16'h1234, 4'd0);
    send_request(REQ_FETCH,   16'h0000, 4'd0);   // token first, task behind it
    send_request(REQ_FETCH,   16'h0000, 4'd0);
    send_request(REQ_PUSH,    16'h8001, 4'd9);
    send_request(REQ_FETCH,   16'hffff, 4'd13);
    wait_for_results();
  endtask

  // overflow: dropped pushes and stop requests that hit a full queue
  task automatic test_queue_full();
    set_workers(5'd1);
    repeat (DEPTH + 2) send_request(REQ_PUSH, HANDLE_W'($urandom), 4'd0);
    send_request(REQ_STOP,  16'h0000, 4'd0);     // only queue is full
    send_request(REQ_FETCH, 16'h0000, 4'd5);
    set_workers(5'd2);
    repeat (2 * DEPTH + 2) send_request(REQ_PUSH, HANDLE_W'($urandom), 4'd7);
    repeat (3) send_request(REQ_FETCH, 16'h0000, 4'd0);
    send_request(REQ_STOP,  16'h0000, 4'd0);     // room in queue 0, queue 1 full
    wait_for_results();
  endtask

  // worker count settings, out-of-range ones among them
  task automatic test_worker_count();
    logic [AW_W-1:0] setting [6] = '{5'd0, 5'd31, 5'd16, 5'd5, 5'd3, 5'd1};
    foreach (setting[k]) begin
      set_workers(setting[k]);
      repeat (15) send_random(500);
    end
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    set_workers(AW_RESET);
    in_gaps     = 1'b0;
    hold_cycles = 120;
    repeat (30) send_random(500);
    wait_for_results();
    in_gaps     = 1'b1;
  endtask

  // random traffic in phases with varying worker count, mix and idling
  task automatic test_random();
    logic [AW_W-1:0] setting [8] = '{5'd4, 5'd2, 5'd31, 5'd1, 5'd3, 5'd0, 5'd16, 5'd4};
    for (int p = 0; p < 8; p++) begin
      set_workers(setting[p]);
      in_gaps  = (p % 3 != 2);
      out_gaps = (p % 4 != 1);
      repeat (110) send_random((p % 2 == 1) ? 350 : 600);
    end
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
  endtask

  initial begin
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_PUSH;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = AW_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_queue_full();
    test_worker_count();
    test_backpressure();
    test_random();

    // everything back, then a wait for any stray result
    wait_for_results();
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
